>>> sv/cdr_pkg.sv
`default_nettype none

package cdr_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [11:0] YEAR_MIN     = 12'd1900;
	localparam logic [11:0] YEAR_SET_MAX = 12'd2100;
	localparam logic [11:0] YEAR_TOP     = 12'd4095;
	localparam logic [3:0]  MONTH_DEC    = 4'd12;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
	localparam logic [4:0]  LAST_DAY_DEC = 5'd31;

	// floor(y / 25) == (y * 1311) >> 15 for every 12-bit y
	localparam logic [22:0] RECIP_25 = 23'd1311;
	localparam int          RECIP_SH = 15;

	// month lengths; codes outside 1..12 read as 31
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
	};

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_CMP = 2'd2;

	typedef enum logic [1:0] {
		KIND_SET,
		KIND_ADD,
		KIND_CMP,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [11:0] year;
	} cmd_t;

	// leap: divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
	function automatic logic is_leap(input logic [11:0] y);
		logic [22:0] prod;
		logic [7:0]  quo;
		logic [11:0] mul25;
		logic [11:0] rem25;
		prod  = 23'(y) * RECIP_25;
		quo   = prod[22:RECIP_SH];
		mul25 = 12'(quo) * 12'd25;
		rem25 = y - mul25;
		return (y[1:0] == 2'd0) && ((rem25 != 12'd0) || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
		if (m == MONTH_FEB && is_leap(y))
			return FEB_LEAP_LEN;
		return MONTH_LEN[m];
	endfunction

endpackage

`default_nettype wire

>>> sv/cdr_front.sv
`default_nettype none

module cdr_front
	import cdr_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             op,
	input  wire logic [3:0]             in_month,
	input  wire logic [4:0]             in_day,
	input  wire logic [11:0]            in_year,
	input  wire logic [COUNT_WIDTH-1:0] day_count,
	output logic                        q_valid,
	input  wire logic                   q_pop,
	output cmd_t                        q_cmd,
	output logic [COUNT_WIDTH-1:0]      q_count
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t                   cmd_mem [QUEUE_DEPTH];
	logic [COUNT_WIDTH-1:0] cnt_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       fill_q;
	logic                   push;
	logic                   pop;
	cmd_t                   cmd_in;

	always_comb begin
		cmd_in.month = in_month;
		cmd_in.day   = in_day;
		cmd_in.year  = in_year;
		case (op)
			OP_SET:  cmd_in.kind = KIND_SET;
			OP_ADD:  cmd_in.kind = KIND_ADD;
			OP_CMP:  cmd_in.kind = KIND_CMP;
			default: cmd_in.kind = KIND_NOP;
		endcase
	end

	assign in_stall = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = cmd_mem[rd_ptr_q];
	assign q_count  = cnt_mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem[wr_ptr_q] <= cmd_in;
			cnt_mem[wr_ptr_q] <= day_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/cdr_back.sv
`default_nettype none

module cdr_back
	import cdr_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	input  wire cmd_t                   q_cmd,
	input  wire logic [COUNT_WIDTH-1:0] q_count,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [3:0]                  out_month,
	output logic [4:0]                  out_day,
	output logic [11:0]                 out_year,
	output logic                        earlier
);

	localparam int CMP_W = (COUNT_WIDTH > 5) ? COUNT_WIDTH : 5;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_ADD  = 2'b10
	} state_t;

	state_t                 state_q;
	logic [3:0]             month_q;
	logic [4:0]             day_q;
	logic [11:0]            year_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic                   out_valid_q;

	logic                   slot_free;
	logic                   res_done;
	logic [4:0]             left;
	logic [CMP_W-1:0]       rem_ext;
	logic [CMP_W-1:0]       left_ext;
	logic [CMP_W-1:0]       rem_after;
	logic                   fits;
	logic                   at_top;
	logic [3:0]             set_month;
	logic [11:0]            set_year;
	logic [4:0]             set_dim;
	logic [4:0]             set_day;
	logic                   is_earlier;

	assign slot_free = !out_valid_q || !out_stall;
	assign q_pop     = q_valid && (state_q == ST_IDLE) && slot_free;
	assign out_valid = out_valid_q;
	assign res_done  = (q_pop && (q_cmd.kind != KIND_ADD)) ||
		((state_q == ST_ADD) && (fits || at_top));

	// one month boundary per cycle while adding
	always_comb begin
		left      = days_in(month_q, year_q) - day_q;
		rem_ext   = CMP_W'(rem_q);
		left_ext  = CMP_W'(left);
		fits      = (rem_ext <= left_ext);
		rem_after = rem_ext - left_ext - CMP_W'(1);
		at_top    = (month_q == MONTH_DEC) && (year_q >= YEAR_TOP);
	end

	always_comb begin
		set_month = (q_cmd.month inside {[4'd1:MONTH_DEC]}) ? q_cmd.month : 4'd1;
		set_year  = (q_cmd.year inside {[YEAR_MIN:YEAR_SET_MAX]}) ? q_cmd.year : YEAR_MIN;
		set_dim   = days_in(set_month, set_year);
		set_day   = (q_cmd.day >= 5'd1 && q_cmd.day <= set_dim) ? q_cmd.day : 5'd1;
		is_earlier = ({year_q, month_q, day_q} < {q_cmd.year, q_cmd.month, q_cmd.day});
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (q_pop) begin
				rem_q <= q_count;
				case (q_cmd.kind)
					KIND_SET: begin
						out_month <= set_month;
						out_day   <= set_day;
						out_year  <= set_year;
						earlier   <= 1'b0;
					end
					KIND_CMP: begin
						out_month <= month_q;
						out_day   <= day_q;
						out_year  <= year_q;
						earlier   <= is_earlier;
					end
					default: begin
						out_month <= month_q;
						out_day   <= day_q;
						out_year  <= year_q;
						earlier   <= 1'b0;
					end
				endcase
			end
		end else begin
			if (!fits)
				rem_q <= COUNT_WIDTH'(rem_after);
			out_month <= month_q;
			out_year  <= year_q;
			earlier   <= 1'b0;
			if (fits)
				out_day <= day_q + rem_ext[4:0];
			else
				out_day <= LAST_DAY_DEC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			month_q     <= 4'd1;
			day_q       <= 5'd1;
			year_q      <= YEAR_MIN;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_done || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd.kind)
							KIND_SET: begin
								month_q <= set_month;
								day_q   <= set_day;
								year_q  <= set_year;
							end
							KIND_ADD: begin
								state_q <= ST_ADD;
							end
							default: ;
						endcase
					end
				end
				ST_ADD: begin
					// output slot is empty here: it was free when the add was taken
					if (fits) begin
						day_q   <= day_q + rem_ext[4:0];
						state_q <= ST_IDLE;
					end else if (at_top) begin
						day_q   <= LAST_DAY_DEC;
						state_q <= ST_IDLE;
					end else begin
						day_q <= 5'd1;
						if (month_q == MONTH_DEC) begin
							month_q <= 4'd1;
							year_q  <= year_q + 12'd1;
						end else begin
							month_q <= month_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/calendar_date_register_core.sv
// Set, compare, unused op: accepted input is queued, then popped into the result register.
// Add: the back-end stepper crosses one month boundary per cycle, then sets the result.
// Throughput: one set/compare per cycle when out_stall is low; an add holds the back end
// while it steps, and the 2-entry command queue keeps accepting input until it is full.
// Reset (arst_n low, async): date = 1900-01-01, queue and result register empty.
`default_nettype none

module calendar_date_register_core
	import cdr_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             op,
	input  wire logic [3:0]             in_month,
	input  wire logic [4:0]             in_day,
	input  wire logic [11:0]            in_year,
	input  wire logic [15:0]            day_count,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [3:0]                  out_month,
	output logic [4:0]                  out_day,
	output logic [11:0]                 out_year,
	output logic                        earlier
);

	logic                   q_valid;
	logic                   q_pop;
	cmd_t                   q_cmd;
	logic [COUNT_WIDTH-1:0] q_count;

	cdr_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.in_month  (in_month),
		.in_day    (in_day),
		.in_year   (in_year),
		.day_count (COUNT_WIDTH'(day_count)),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.q_count   (q_count)
	);

	cdr_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.q_count   (q_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_month (out_month),
		.out_day   (out_day),
		.out_year  (out_year),
		.earlier   (earlier)
	);

endmodule

`default_nettype wire

>>> sim/calendar_date_register_core_tb.sv
module calendar_date_register_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cdr_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int IDLE_LIMIT   = 20000;
	localparam int RANDOM_ITEMS = 1325;
	localparam int CALM_TAIL    = 150;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_ITEMS   = 40;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [11:0] year;
		logic        earlier;
	} date_result_t;

	class date_tracker;
		logic [3:0]   cur_month;
		logic [4:0]   cur_day;
		logic [11:0]  cur_year;
		date_result_t expected_dates[$];
		int           errors;

		function new();
			cur_month = 4'd1;
			cur_day = 5'd1;
			cur_year = YEAR_MIN;
			errors = 0;
		endfunction

		function bit leap_year(int unsigned y);
			return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
		endfunction

		function int unsigned month_length(int unsigned m, int unsigned y);
			int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			if (m < 1 || m > 12)
				return 31;
			if (m == 2 && leap_year(y))
				return FEB_LEAP_LEN;
			return lens[m];
		endfunction

		// walks month by month; pins at the last day of the top year
		function void advance_days(int unsigned count);
			int unsigned rest;
			int unsigned left;
			int unsigned m;
			int unsigned d;
			int unsigned y;
			rest = count;
			m = cur_month;
			d = cur_day;
			y = cur_year;
			while (rest > 0) begin
				left = month_length(m, y) - d;
				if (rest <= left) begin
					d += rest;
					rest = 0;
				end else if (m == MONTH_DEC && y >= YEAR_TOP) begin
					d = LAST_DAY_DEC;
					rest = 0;
				end else begin
					rest -= left + 1;
					d = 1;
					if (m < 12) begin
						m++;
					end else begin
						m = 1;
						y++;
					end
				end
			end
			cur_month = 4'(m);
			cur_day = 5'(d);
			cur_year = 12'(y);
		endfunction

		function void note_input(logic [1:0] op_code, logic [3:0] m, logic [4:0] d,
				logic [11:0] y, logic [15:0] count);
			logic e;
			e = 1'b0;
			case (op_code)
				OP_SET: begin
					cur_month = (m >= 1 && m <= 12) ? m : 4'd1;
					cur_year = (y >= YEAR_MIN && y <= YEAR_SET_MAX) ? y : YEAR_MIN;
					cur_day = (d >= 1 && d <= month_length(cur_month, cur_year)) ? d : 5'd1;
				end
				OP_ADD: advance_days(count);
				OP_CMP: e = ({cur_year, cur_month, cur_day} < {y, m, d});
				default: ;
			endcase
			expected_dates.push_back('{cur_month, cur_day, cur_year, e});
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [3:0] m, logic [4:0] d, logic [11:0] y, logic e);
			date_result_t want;
			if (expected_dates.size() == 0) begin
				report($sformatf("unexpected transaction %0d-%0d-%0d", y, m, d));
				return;
			end
			want = expected_dates.pop_front();
			if (m !== want.month)
				report($sformatf("out_month got %0d want %0d", m, want.month));
			if (d !== want.day)
				report($sformatf("out_day got %0d want %0d", d, want.day));
			if (y !== want.year)
				report($sformatf("out_year got %0d want %0d", y, want.year));
			if (e !== want.earlier)
				report($sformatf("earlier got %0d want %0d", e, want.earlier));
		endtask

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_SET;
	logic [3:0]  in_month = '0;
	logic [4:0]  in_day = '0;
	logic [11:0] in_year = '0;
	logic [15:0] day_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [11:0] out_year;
	logic        earlier;

	date_tracker tracker = new();
	int          gap_pct = 0;
	bit          calm_tail = 1'b0;
	bit          hold_request = 1'b0;
	int          quiet_cycles = 0;

	calendar_date_register_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.in_month(in_month),
		.in_day(in_day),
		.in_year(in_year),
		.day_count(day_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_month(out_month),
		.out_day(out_day),
		.out_year(out_year),
		.earlier(earlier)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one transaction; returns at the edge where it is taken, or after a random gap if allowed
	task automatic send_item(input logic [1:0] op_code, input logic [3:0] m, input logic [4:0] d,
			input logic [11:0] y, input logic [15:0] count, input bit allow_gap);
		in_valid <= 1'b1;
		op <= op_code;
		in_month <= m;
		in_day <= d;
		in_year <= y;
		day_count <= count;
		do @(posedge clk); while (in_stall);
		tracker.note_input(op_code, m, d, y, count);
		if (allow_gap && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_item(input bit allow_gap);
		int unsigned pick;
		int unsigned near;
		logic [1:0]  op_code;
		logic [3:0]  m;
		logic [4:0]  d;
		logic [11:0] y;
		logic [15:0] count;
		pick = $urandom_range(0, 99);
		m = 4'($urandom_range(0, 15));
		d = 5'($urandom_range(0, 31));
		y = 12'($urandom_range(0, 4095));
		count = 16'($urandom_range(0, 65535));
		if (pick < 30) begin
			op_code = OP_SET;
			if ($urandom_range(0, 3) != 0) begin
				m = 4'($urandom_range(1, 12));
				d = 5'($urandom_range(1, 31));
				y = 12'($urandom_range(1896, 2104));
			end
		end else if (pick < 65) begin
			op_code = OP_ADD;
			near = $urandom_range(0, 99);
			if (near < 60)
				count = 16'($urandom_range(0, 40));
			else if (near < 85)
				count = 16'($urandom_range(0, 400));
			else if (near < 95)
				count = 16'($urandom_range(0, 4000));
		end else if (pick < 95) begin
			op_code = OP_CMP;
			if ($urandom_range(0, 1) == 0) begin
				m = tracker.cur_month;
				d = tracker.cur_day;
				y = tracker.cur_year;
				near = $urandom_range(0, 3);
				// equal, or one field off by one either way
				if (near == 1)
					y = $urandom_range(0, 1) ? y + 12'd1 : y - 12'd1;
				else if (near == 2)
					m = $urandom_range(0, 1) ? m + 4'd1 : m - 4'd1;
				else if (near == 3)
					d = $urandom_range(0, 1) ? d + 5'd1 : d - 5'd1;
			end
		end else begin
			op_code = OP_NOP;
		end
		send_item(op_code, m, d, y, count, allow_gap);
	endtask

	// receiving side: checks, random stall bursts, one long hold-off
	initial begin
		int burst_left;
		int hold_left;
		int stall_pct;
		int cycles;
		burst_left = 0;
		hold_left = 0;
		stall_pct = 0;
		cycles = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				tracker.check_result(out_month, out_day, out_year, earlier);
			if (cycles % 200 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 12;
					default: stall_pct = 35;
				endcase
			end
			cycles++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm_tail) begin
				burst_left = 0;
				out_stall <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				burst_left = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset date, invalid fields on set, leap rules
		send_item(OP_CMP, 4'd1, 5'd2, 12'd1900, 16'd0, 1'b0);
		send_item(OP_SET, 4'd0, 5'd0, 12'd0, 16'hFFFF, 1'b0);
		send_item(OP_SET, 4'd2, 5'd29, 12'd2000, 16'd0, 1'b0);
		send_item(OP_SET, 4'd2, 5'd29, 12'd1900, 16'd0, 1'b0);
		send_item(OP_SET, 4'd2, 5'd28, 12'd2024, 16'd0, 1'b0);
		send_item(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd1, 1'b0);
		send_item(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd1, 1'b0);
		send_item(OP_SET, 4'd15, 5'd31, 12'd4095, 16'd0, 1'b0);
		send_item(OP_SET, 4'd4, 5'd31, 12'd2100, 16'd0, 1'b0);
		send_item(OP_SET, 4'd12, 5'd31, 12'd2100, 16'd0, 1'b0);
		send_item(OP_ADD, 4'd15, 5'd31, 12'd4095, 16'd0, 1'b0);
		send_item(OP_ADD, 4'd0, 5'd0, 12'd0, 16'd1, 1'b0);
		// raw compare values, no validation
		send_item(OP_CMP, 4'd15, 5'd31, 12'd4095, 16'd0, 1'b0);
		send_item(OP_CMP, 4'd0, 5'd0, 12'd0, 16'd0, 1'b0);
		send_item(OP_NOP, 4'd15, 5'd31, 12'd4095, 16'hFFFF, 1'b0);
		// full counts until the date pins at the top of range
		for (i = 0; i < 12; i++)
			send_item(OP_ADD, 4'd0, 5'd0, 12'd0, 16'hFFFF, 1'b0);
		send_item(OP_CMP, 4'd12, 5'd31, 12'd4095, 16'd0, 1'b0);
		drain();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 8;
					default: gap_pct = 25;
				endcase
			end
			if (i == HOLD_AT)
				hold_request = 1'b1;
			if (i == 600)
				drain();
			if (i == RANDOM_ITEMS - CALM_TAIL)
				calm_tail = 1'b1;
			random_item(!calm_tail && !(i >= HOLD_AT && i < HOLD_AT + HOLD_ITEMS));
		end
		drain();
		repeat (20) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
